// File: hw/rtl/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// Shared widths, mode codes and segment tables for the seven-segment scanner.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int OP_W       = 2;
  localparam int VALUE_W    = 17;
  localparam int SEL_W      = 4;
  localparam int SEG_W      = 8;
  localparam int SCAN_W     = 4;
  localparam int BCD_DIGITS = 6;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(11);

  localparam logic [OP_W-1:0] OP_INT   = 2'd0;
  localparam logic [OP_W-1:0] OP_ANGLE = 2'd1;
  localparam logic [OP_W-1:0] OP_HIGH  = 2'd2;
  localparam logic [OP_W-1:0] OP_LOW   = 2'd3;

  // Segment pattern of one decimal digit, bit0 is segment a.
  function automatic logic [6:0] digit_pattern(input logic [3:0] d);
    logic [6:0] p;
    unique case (d)
      4'd0:    p = 7'h3F;
      4'd1:    p = 7'h06;
      4'd2:    p = 7'h5B;
      4'd3:    p = 7'h4F;
      4'd4:    p = 7'h66;
      4'd5:    p = 7'h6D;
      4'd6:    p = 7'h7D;
      4'd7:    p = 7'h07;
      4'd8:    p = 7'h7F;
      4'd9:    p = 7'h6F;
      default: p = 7'h00;
    endcase
    return p;
  endfunction

  function automatic logic [6:0] word_high(input logic [1:0] idx);
    logic [6:0] p;
    unique case (idx)
      2'd0: p = 7'h76;
      2'd1: p = 7'h10;
      2'd2: p = 7'h6F;
      2'd3: p = 7'h74;
    endcase
    return p;
  endfunction

  function automatic logic [6:0] word_low(input logic [1:0] idx);
    logic [6:0] p;
    unique case (idx)
      2'd0: p = 7'h38;
      2'd1: p = 7'h5C;
      2'd2: p = 7'h1C;
      2'd3: p = 7'h1C;
    endcase
    return p;
  endfunction

  // Scan counter modulo three; the counter never leaves 0..11.
  function automatic logic [1:0] scan_mod3(input logic [SCAN_W-1:0] s);
    logic [1:0] r;
    unique case (s)
      4'd0, 4'd3, 4'd6, 4'd9:  r = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10: r = 2'd1;
      4'd2, 4'd5, 4'd8, 4'd11: r = 2'd2;
      default:                 r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/mss_bcd_conv.sv
// ----------------------------------------------------------------------------
// mss_bcd_conv
// Iterative shift-add-3 binary to decimal converter, one bit per cycle.
// ----------------------------------------------------------------------------
module mss_bcd_conv #(
  parameter int ValueW = mss_pkg::VALUE_W,
  parameter int Digits = mss_pkg::BCD_DIGITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ValueW-1:0] bin,
  output logic              busy,
  output logic [4*Digits-1:0] bcd
);
  import mss_pkg::*;

  localparam int CntW = $clog2(ValueW + 1);

  logic [ValueW-1:0]   shift_r, shift_nxt;
  logic [4*Digits-1:0] bcd_r, bcd_nxt, adj;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;

  // Add-3 correction on every digit, then shift in the next binary bit.
  always_comb begin
    for (int i = 0; i < Digits; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                 : bcd_r[4*i +: 4];
    end
    shift_nxt = shift_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    if (start) begin
      shift_nxt = bin;
      bcd_nxt   = '0;
      cnt_nxt   = CntW'(ValueW);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      bcd_nxt   = {adj[4*Digits-2:0], shift_r[ValueW-1]};
      shift_nxt = {shift_r[ValueW-2:0], 1'b0};
      cnt_nxt   = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    shift_r <= shift_nxt;
    bcd_r   <= bcd_nxt;
  end

  assign busy = busy_r;
  assign bcd  = bcd_r;

endmodule

// File: hw/rtl/mss_seg_sel.sv
// ----------------------------------------------------------------------------
// mss_seg_sel
// Picks the lit position and its segment pattern from mode, value and scan.
// ----------------------------------------------------------------------------
module mss_seg_sel (
  input  logic [mss_pkg::OP_W-1:0]    op,
  input  logic [mss_pkg::VALUE_W-1:0] value,
  input  logic [mss_pkg::SCAN_W-1:0]  scan,
  input  logic [mss_pkg::BCD_W-1:0]   bcd,
  output logic [mss_pkg::SEL_W-1:0]   digit_select,
  output logic [mss_pkg::SEG_W-1:0]   segments
);
  import mss_pkg::*;

  logic [1:0] idx;
  logic [2:0] k;
  logic       point;
  logic [3:0] digit;
  logic       ge10, ge100, ge1000, ge10000;

  assign ge10    = value >= VALUE_W'(10);
  assign ge100   = value >= VALUE_W'(100);
  assign ge1000  = value >= VALUE_W'(1000);
  assign ge10000 = value >= VALUE_W'(10000);

  always_comb begin
    idx   = scan[1:0];
    k     = 3'd0;
    point = 1'b0;
    unique case (op)
      OP_INT: begin
        if (ge1000) begin
          idx = scan[1:0];
        end else if (ge100) begin
          idx = scan_mod3(scan) + 2'd1;
        end else if (ge10) begin
          idx = {1'b1, scan[0]};
        end else begin
          idx = 2'd3;
        end
        k = 3'd3 - {1'b0, idx};
      end
      OP_ANGLE: begin
        idx = scan_mod3(scan);
        if (ge10000) begin
          k = 3'd4 - {1'b0, idx};
        end else if (ge1000) begin
          k     = 3'd3 - {1'b0, idx};
          point = (idx == 2'd1);
        end else begin
          k     = 3'd2 - {1'b0, idx};
          point = (idx == 2'd0);
        end
      end
      OP_HIGH, OP_LOW: begin
        idx = scan[1:0];
      end
    endcase
  end

  assign digit = bcd[4*k +: 4];

  always_comb begin
    digit_select = SEL_W'(1) << idx;
    unique case (op)
      OP_HIGH: segments = {1'b0, word_high(idx)};
      OP_LOW:  segments = {1'b0, word_low(idx)};
      OP_INT, OP_ANGLE: segments = {point, digit_pattern(digit)};
    endcase
  end

endmodule

// File: hw/rtl/multiplexed_seven_segment_scanner.sv
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_scanner
// Four-position multiplexed seven-segment scanner with decimal conversion.
// ----------------------------------------------------------------------------
// Each input transaction on the in_ channel is one refresh tick carrying a
// mode and a value. The block answers with exactly one output transaction
// on the out_ channel: a one-hot position select and that position's
// segment pattern (a to g plus the decimal point).
// Integer and angle ticks advance a scan counter that runs modulo 12 before
// it picks the position; the fixed words only read it.
// The value is turned into six decimal digits by a shift-add-3 converter
// that handles one binary bit per cycle. A tick runs through the conversion,
// a state in which the sequencer sees the converter finish and a finish
// state that picks the digit and loads the output register; in_tready
// rises at the same edge as the result becomes valid, so a new tick is
// taken only once the previous result is in the output register.
// The result sits in an output register; if the receiver stalls, the block
// still takes and converts one more tick, then waits with it until
// out_tready frees the register, and in_tready stays low meanwhile.
// A synchronous active-low reset clears the scan counter, the sequencer and
// the output valid flag.
// ----------------------------------------------------------------------------
module multiplexed_seven_segment_scanner (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mss_pkg::IN_DATA_W-1:0]  in_tdata,   // [1:0] op, [18:2] value
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mss_pkg::OUT_DATA_W-1:0] out_tdata   // [3:0] digit_select, [11:4] segments
);
  import mss_pkg::*;

  localparam int ValueW = VALUE_W;
  localparam int Digits = BCD_DIGITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_FINISH
  } state_t;

  state_t              state_r;
  logic [OP_W-1:0]     op_r;
  logic [ValueW-1:0]   value_r;
  logic [SCAN_W-1:0]   scan_r;
  logic                out_valid_r;
  logic [SEL_W-1:0]    sel_r;
  logic [SEG_W-1:0]    seg_r;

  logic                in_fire;
  logic [OP_W-1:0]     in_op;
  logic [ValueW-1:0]   in_value;
  logic                conv_busy;
  logic [4*Digits-1:0] bcd;
  logic [SEL_W-1:0]    sel_nxt;
  logic [SEG_W-1:0]    seg_nxt;
  logic                out_free;

  assign in_op     = in_tdata[OP_W-1:0];
  assign in_value  = in_tdata[OP_W +: ValueW];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  mss_bcd_conv #(
    .ValueW (ValueW),
    .Digits (Digits)
  ) u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .bin   (in_value),
    .busy  (conv_busy),
    .bcd   (bcd)
  );

  mss_seg_sel u_sel (
    .op           (op_r),
    .value        (value_r),
    .scan         (scan_r),
    .bcd          (bcd),
    .digit_select (sel_nxt),
    .segments     (seg_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A load in the finish state takes the place of the clear.
      if (out_valid_r && out_tready && state_r != ST_FINISH) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            op_r    <= in_op;
            value_r <= in_value;
            // Only the numeric modes move the scan.
            if (in_op == OP_INT || in_op == OP_ANGLE) begin
              scan_r <= (scan_r == SCAN_LAST) ? '0 : scan_r + 1'b1;
            end
            state_r <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (!conv_busy) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            sel_r       <= sel_nxt;
            seg_r       <= seg_nxt;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - SEL_W - SEG_W){1'b0}}, seg_r, sel_r};

endmodule
